>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the line classifier RTL.
// Each macro expects signals named clk and rst_n in the enclosing module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CLC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define CLC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/clc_pkg.sv
// ----------------------------------------------------------------------------
// Config line classifier package
// Types, character constants and lookup functions shared by the block.
// ----------------------------------------------------------------------------
package clc_pkg;

  localparam int unsigned WIN_DEPTH = 11;
  localparam int unsigned POS_W     = 5;
  localparam logic [POS_W-1:0] POS_MAX = 5'd31;

  // Verdict kinds.
  localparam logic [2:0] KIND_IGNORED  = 3'd0;
  localparam logic [2:0] KIND_UNSET    = 3'd1;
  localparam logic [2:0] KIND_BUILTIN  = 3'd2;
  localparam logic [2:0] KIND_MODULE   = 3'd3;
  localparam logic [2:0] KIND_STRING   = 3'd4;
  localparam logic [2:0] KIND_INTEGER  = 3'd5;
  localparam logic [2:0] KIND_ERROR    = 3'd6;

  // Characters.
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_Y     = 8'h79;
  localparam logic [7:0] CH_M     = 8'h6D;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_X_LO  = 8'h78;
  localparam logic [7:0] CH_X_UP  = 8'h58;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_C     = 8'h43;

  // Tail of a disabled line, " is not set". Element 0 is the oldest byte in
  // the window, so the string reads backwards here.
  localparam logic [WIN_DEPTH-1:0][7:0] OFF_TAIL = "tes ton si ";

  typedef enum logic [7:0] {
    PH_START    = 8'b0000_0001,
    PH_HASHPRE  = 8'b0000_0010,
    PH_DISABLED = 8'b0000_0100,
    PH_COMMENT  = 8'b0000_1000,
    PH_NAMEPRE  = 8'b0001_0000,
    PH_NAME     = 8'b0010_0000,
    PH_VALUE    = 8'b0100_0000,
    PH_ERROR    = 8'b1000_0000
  } phase_t;

  typedef struct packed {
    logic [1:0] cnt;
    logic       hexbad;
    logic       decbad;
    logic       hexpre;
    logic       sign;
  } num_track_t;

  typedef struct packed {
    logic [7:0] name_char;
    logic       is_verdict;
    logic [2:0] line_kind;
  } result_t;

  // Expected bytes of "# CONFIG_" by position.
  function automatic logic [7:0] off_lead_char(input logic [3:0] idx);
    logic [7:0] ch;
    unique case (idx)
      4'd0:    ch = 8'h23;
      4'd1:    ch = 8'h20;
      4'd2:    ch = 8'h43;
      4'd3:    ch = 8'h4F;
      4'd4:    ch = 8'h4E;
      4'd5:    ch = 8'h46;
      4'd6:    ch = 8'h49;
      4'd7:    ch = 8'h47;
      4'd8:    ch = 8'h5F;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // Expected bytes of "CONFIG_" by position.
  function automatic logic [7:0] on_lead_char(input logic [2:0] idx);
    logic [7:0] ch;
    unique case (idx)
      3'd0:    ch = 8'h43;
      3'd1:    ch = 8'h4F;
      3'd2:    ch = 8'h4E;
      3'd3:    ch = 8'h46;
      3'd4:    ch = 8'h49;
      3'd5:    ch = 8'h47;
      3'd6:    ch = 8'h5F;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic is_dec(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return is_dec(c) || ((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46));
  endfunction

endpackage

>>> hw/rtl/clc_if.sv
// ----------------------------------------------------------------------------
// Config line classifier channels
// Valid/ready interfaces for the byte input and the result output.
// ----------------------------------------------------------------------------
interface clc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] line_byte;
  logic       line_end;

  modport source (output valid, output line_byte, output line_end, input ready);
  modport sink   (input valid, input line_byte, input line_end, output ready);
endinterface

interface clc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] name_char;
  logic       is_verdict;
  logic [2:0] line_kind;

  modport source (output valid, output name_char, output is_verdict, output line_kind,
                  input ready);
  modport sink   (input valid, input name_char, input is_verdict, input line_kind,
                  output ready);
endinterface

>>> hw/rtl/clc_classifier.sv
// ----------------------------------------------------------------------------
// Config line classifier core
// Per-line state registers and the combinational byte update and verdict.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module clc_classifier (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  logic [7:0]       line_byte,
  input  logic             line_end,
  output logic             res_valid,
  output clc_pkg::result_t res
);

  clc_pkg::phase_t                             phase_r, phase_nxt;
  logic [clc_pkg::POS_W-1:0]                   pos_r, pos_nxt;
  logic [clc_pkg::WIN_DEPTH-1:0][7:0]          win_r, win_nxt;
  logic [7:0]                                  first_r, first_nxt;
  logic [7:0]                                  last_r, last_nxt;
  logic [1:0]                                  vlen_r, vlen_nxt;
  clc_pkg::num_track_t                         nt_r, nt_nxt;

  logic [2:0] verdict;
  logic       int_ok;
  logic       emit;
  logic [7:0] emit_ch;

  // Integer test on the tracked value.
  always_comb begin
    if (nt_r.cnt == 2'd0) begin
      int_ok = 1'b0;
    end else if (nt_r.hexpre && (nt_r.cnt == 2'd3)) begin
      int_ok = !nt_r.hexbad;
    end else begin
      int_ok = !nt_r.decbad;
    end
  end

  // Verdict from the state reached before the end-of-line transaction.
  always_comb begin
    verdict = clc_pkg::KIND_ERROR;
    unique case (phase_r)
      clc_pkg::PH_START, clc_pkg::PH_HASHPRE, clc_pkg::PH_COMMENT: begin
        verdict = clc_pkg::KIND_IGNORED;
      end
      clc_pkg::PH_DISABLED: begin
        verdict = (win_r == clc_pkg::OFF_TAIL) ? clc_pkg::KIND_UNSET : clc_pkg::KIND_ERROR;
      end
      clc_pkg::PH_VALUE: begin
        if (vlen_r == 2'd0) begin
          verdict = clc_pkg::KIND_ERROR;
        end else if ((vlen_r == 2'd1) && (first_r == clc_pkg::CH_Y)) begin
          verdict = clc_pkg::KIND_BUILTIN;
        end else if ((vlen_r == 2'd1) && (first_r == clc_pkg::CH_M)) begin
          verdict = clc_pkg::KIND_MODULE;
        end else if ((vlen_r != 2'd1) && (first_r == clc_pkg::CH_QUOTE) &&
                     (last_r == clc_pkg::CH_QUOTE)) begin
          verdict = clc_pkg::KIND_STRING;
        end else begin
          verdict = int_ok ? clc_pkg::KIND_INTEGER : clc_pkg::KIND_ERROR;
        end
      end
      default: begin
        verdict = clc_pkg::KIND_ERROR;
      end
    endcase
  end

  // Byte update.
  always_comb begin
    phase_nxt = phase_r;
    first_nxt = first_r;
    last_nxt  = last_r;
    vlen_nxt  = vlen_r;
    nt_nxt    = nt_r;
    emit      = 1'b0;
    emit_ch   = line_byte;
    win_nxt   = {line_byte, win_r[clc_pkg::WIN_DEPTH-1:1]};
    pos_nxt   = (pos_r == clc_pkg::POS_MAX) ? pos_r : pos_r + 1'b1;

    unique case (phase_r)
      clc_pkg::PH_START: begin
        if (line_byte == clc_pkg::CH_HASH) begin
          phase_nxt = clc_pkg::PH_HASHPRE;
        end else if (line_byte == clc_pkg::CH_C) begin
          phase_nxt = clc_pkg::PH_NAMEPRE;
          emit      = 1'b1;
        end else begin
          phase_nxt = clc_pkg::PH_ERROR;
        end
      end
      clc_pkg::PH_HASHPRE: begin
        if ((pos_r < 5'd9) && (line_byte == clc_pkg::off_lead_char(pos_r[3:0]))) begin
          if (pos_r == 5'd8) begin
            phase_nxt = clc_pkg::PH_DISABLED;
          end
        end else begin
          phase_nxt = clc_pkg::PH_COMMENT;
        end
      end
      clc_pkg::PH_NAMEPRE: begin
        if ((pos_r < 5'd7) && (line_byte == clc_pkg::on_lead_char(pos_r[2:0]))) begin
          emit = 1'b1;
          if (pos_r == 5'd6) begin
            phase_nxt = clc_pkg::PH_NAME;
          end
        end else begin
          phase_nxt = clc_pkg::PH_ERROR;
        end
      end
      clc_pkg::PH_NAME: begin
        if (line_byte == clc_pkg::CH_EQ) begin
          phase_nxt = clc_pkg::PH_VALUE;
        end else begin
          emit = 1'b1;
        end
      end
      clc_pkg::PH_DISABLED: begin
        // The byte eleven places back leaves the window as a name byte.
        if (pos_r >= 5'd13) begin
          emit    = 1'b1;
          emit_ch = win_r[0];
        end
      end
      clc_pkg::PH_VALUE: begin
        if (vlen_r == 2'd0) begin
          first_nxt = line_byte;
        end
        last_nxt = line_byte;
        if ((vlen_r == 2'd0) && (line_byte == clc_pkg::CH_MINUS)) begin
          nt_nxt.sign = 1'b1;
        end else begin
          if (!clc_pkg::is_dec(line_byte)) begin
            nt_nxt.decbad = 1'b1;
          end
          if (nt_r.cnt == 2'd0) begin
            if (line_byte != clc_pkg::CH_ZERO) begin
              nt_nxt.hexbad = 1'b1;
            end
          end else if (nt_r.cnt == 2'd1) begin
            // Second digit position: an 'x' after a leading zero opens a hex number.
            if (!nt_r.hexbad &&
                ((line_byte == clc_pkg::CH_X_LO) || (line_byte == clc_pkg::CH_X_UP))) begin
              nt_nxt.hexpre = 1'b1;
            end
            nt_nxt.hexbad = 1'b0;
          end else if (!clc_pkg::is_hex(line_byte)) begin
            nt_nxt.hexbad = 1'b1;
          end
          if (nt_r.cnt != 2'd3) begin
            nt_nxt.cnt = nt_r.cnt + 2'd1;
          end
        end
        if (vlen_r != 2'd3) begin
          vlen_nxt = vlen_r + 2'd1;
        end
      end
      default: begin
        phase_nxt = phase_r;
      end
    endcase

    // The end of a line clears everything for the next one.
    if (line_end) begin
      phase_nxt = clc_pkg::PH_START;
      pos_nxt   = '0;
      win_nxt   = '0;
      first_nxt = '0;
      last_nxt  = '0;
      vlen_nxt  = '0;
      nt_nxt    = '0;
    end
  end

  assign res_valid      = line_end || emit;
  assign res.name_char  = line_end ? 8'h00 : emit_ch;
  assign res.is_verdict = line_end;
  assign res.line_kind  = line_end ? verdict : clc_pkg::KIND_IGNORED;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= clc_pkg::PH_START;
      pos_r   <= '0;
      win_r   <= '0;
      first_r <= '0;
      last_r  <= '0;
      vlen_r  <= '0;
      nt_r    <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      win_r   <= win_nxt;
      first_r <= first_nxt;
      last_r  <= last_nxt;
      vlen_r  <= vlen_nxt;
      nt_r    <= nt_nxt;
    end
  end

  `CLC_ASSERT_NEXT(a_line_end_clears, accept && line_end,
                   (phase_r == clc_pkg::PH_START) && (pos_r == '0) && (vlen_r == 2'd0),
                   "line state not cleared after end of line")
  `CLC_ASSERT_NOW(a_name_kind_zero, res_valid && !res.is_verdict,
                  res.line_kind == clc_pkg::KIND_IGNORED,
                  "name byte carries a verdict kind")
  `CLC_ASSERT_NEXT(a_pos_saturates, accept && !line_end && (pos_r == clc_pkg::POS_MAX),
                   pos_r == clc_pkg::POS_MAX, "position counter wrapped")
  `CLC_ASSERT_NOW(a_value_len_tracks, (phase_r != clc_pkg::PH_VALUE),
                  (vlen_r == 2'd0) && (nt_r == '0),
                  "value tracking active outside the value phase")

endmodule

>>> hw/rtl/clc_out_reg.sv
// ----------------------------------------------------------------------------
// Config line classifier output register
// Holds one result transaction until the receiver takes it.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module clc_out_reg (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  clc_pkg::result_t load_data,
  input  logic             out_ready,
  output logic             out_valid,
  output clc_pkg::result_t out_data,
  output logic             can_load
);

  logic             valid_r, valid_nxt;
  clc_pkg::result_t data_r;

  // Space is free when empty or when the held result leaves this cycle.
  assign can_load  = !valid_r || out_ready;
  assign valid_nxt = load || (valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_data;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

  `CLC_ASSERT_NOW(a_no_overwrite, valid_r && !out_ready, !load,
                  "stalled result overwritten")
  `CLC_ASSERT_NEXT(a_load_shows, load, valid_r, "loaded result not presented")

endmodule

>>> hw/rtl/config_line_classifier_top.sv
// ----------------------------------------------------------------------------
// Config line classifier
// Classifies configuration text lines and passes out the option names.
// ----------------------------------------------------------------------------
// The input channel carries one byte of a line per transaction; a transaction
// with line_end set closes the line and its byte is ignored. Each line gives
// name-byte results (is_verdict low) and then exactly one verdict result
// (is_verdict high) with the line kind. Name bytes only count when the
// verdict is unset, built-in, module, string or integer.
// Every input transaction is handled in the cycle it is accepted: the line
// state is updated and any result goes straight into the output register, so
// a result appears on the output channel in the cycle after its input byte.
// While the receiver keeps taking results, one byte is accepted every cycle.
// Bytes of a disabled line come out eleven positions late, through a shift
// window, so that the " is not set" tail never appears as name bytes.
// When the receiver stalls, the held result stays put and input is refused
// for as long as the output register is full, even for a byte that would
// give no result; in the cycle the receiver takes the held result, input is
// accepted again.
// A synchronous active-low reset returns the block to the start of a line
// with no result pending.
// ----------------------------------------------------------------------------
module config_line_classifier_top (
  input  logic      clk,
  input  logic      rst_n,
  clc_in_if.sink    in_ch,
  clc_out_if.source out_ch
);

  logic             accept;
  logic             res_valid;
  clc_pkg::result_t res;
  logic             can_load;
  clc_pkg::result_t out_data;

  // Every transaction may yield a result, so input waits for register space.
  assign in_ch.ready = can_load;
  assign accept      = in_ch.valid && can_load;

  clc_classifier u_classifier (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .line_byte (in_ch.line_byte),
    .line_end  (in_ch.line_end),
    .res_valid (res_valid),
    .res       (res)
  );

  clc_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (accept && res_valid),
    .load_data (res),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .out_data  (out_data),
    .can_load  (can_load)
  );

  assign out_ch.name_char  = out_data.name_char;
  assign out_ch.is_verdict = out_data.is_verdict;
  assign out_ch.line_kind  = out_data.line_kind;

endmodule
